FILE: hdl/kruskal_union_find_edge_filter_defines.svh
// Assertion macros shared by the edge filter RTL.
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_DEFINES_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KUFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KUFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/kufe_pkg.sv
// Package with the types and constants of the edge filter.
`default_nettype none
package kufe_pkg;

	localparam int MAX_NODES = 1024;
	localparam int NODE_W    = 10;
	localparam int ADDR_W    = $clog2(MAX_NODES);

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_WT,
		ST_COMP_RD,
		ST_COMP_WR,
		ST_LINK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		addr_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		logic accepted;
		node_t root_node;
	} result_t;

	typedef struct packed {
		logic clearing;
		logic push;
	} eng_stat_t;

endpackage
`default_nettype wire

FILE: hdl/kufe_edge_if.sv
// Edge input channel: valid, ready and the two endpoint node numbers.
`default_nettype none
interface kufe_edge_if;
	logic valid;
	logic ready;
	kufe_pkg::node_t node_a;
	kufe_pkg::node_t node_b;

	modport source (output valid, output node_a, output node_b, input ready);
	modport sink (input valid, input node_a, input node_b, output ready);
endinterface
`default_nettype wire

FILE: hdl/kufe_result_if.sv
// Result channel: valid, ready, the accept flag and the component root.
`default_nettype none
interface kufe_result_if;
	logic valid;
	logic ready;
	logic accepted;
	kufe_pkg::node_t root_node;

	modport source (output valid, output accepted, output root_node, input ready);
	modport sink (input valid, input accepted, input root_node, output ready);
endinterface
`default_nettype wire

FILE: hdl/kufe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module kufe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/kufe_engine.sv
// Union-find sequencer: root walks, path compression, linking and store clearing.
`default_nettype none
module kufe_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	kufe_edge_if.sink             edge_in,
	input  wire logic             res_ready,
	output kufe_pkg::result_t     res,
	output kufe_pkg::eng_stat_t   stat,
	output kufe_pkg::mem_req_t    mem_req,
	input  wire kufe_pkg::addr_t  mem_rdata
);
	import kufe_pkg::*;

	localparam addr_t LAST_ADDR = addr_t'(MAX_NODES - 1);

	state_t  state_q;
	state_t  state_d;
	addr_t   clr_q;
	logic    side_b_q;
	addr_t   na_q;
	addr_t   nb_q;
	addr_t   cur_q;
	addr_t   root_q;
	addr_t   ra_q;
	result_t res_q;

	logic    in_range;
	addr_t   start;
	addr_t   phase_root;
	logic    found;
	logic    phase_end;

	assign in_range   = (int'(edge_in.node_a) < MAX_NODES) && (int'(edge_in.node_b) < MAX_NODES);
	assign start      = side_b_q ? nb_q : na_q;
	assign found      = (mem_rdata == cur_q);
	assign phase_root = (state_q == ST_FIND_WT) ? cur_q : root_q;

	always_comb begin
		phase_end = 1'b0;
		if (state_q == ST_FIND_WT) begin
			phase_end = found && (start == cur_q);
		end else if (state_q == ST_COMP_WR) begin
			phase_end = (mem_rdata == root_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (edge_in.valid) begin
					state_d = in_range ? ST_FIND_RD : ST_DONE;
				end
			end
			ST_FIND_RD: state_d = ST_FIND_WT;
			ST_FIND_WT: begin
				if (!found) begin
					state_d = ST_FIND_RD;
				end else if (phase_end) begin
					state_d = side_b_q ? ST_LINK : ST_FIND_RD;
				end else begin
					state_d = ST_COMP_RD;
				end
			end
			ST_COMP_RD: state_d = ST_COMP_WR;
			ST_COMP_WR: begin
				if (phase_end) begin
					state_d = side_b_q ? ST_LINK : ST_FIND_RD;
				end else begin
					state_d = ST_COMP_RD;
				end
			end
			ST_LINK: state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		edge_in.ready = 1'b0;
		mem_req       = '0;
		stat          = '0;
		unique case (state_q)
			ST_CLEAR: begin
				stat.clearing = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = clr_q;
			end
			ST_IDLE: edge_in.ready = 1'b1;
			ST_FIND_RD, ST_COMP_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = cur_q;
			end
			ST_COMP_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cur_q;
				mem_req.wdata = root_q;
			end
			ST_LINK: begin
				mem_req.we    = (ra_q != root_q);
				mem_req.waddr = ra_q;
				mem_req.wdata = root_q;
			end
			ST_DONE: stat.push = res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			side_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + addr_t'(1);
			end
			if (state_q == ST_IDLE) begin
				side_b_q <= 1'b0;
			end else if (phase_end && !side_b_q) begin
				side_b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				na_q  <= addr_t'(edge_in.node_a);
				nb_q  <= addr_t'(edge_in.node_b);
				cur_q <= addr_t'(edge_in.node_a);
				res_q <= '0;
			end
			ST_FIND_WT: begin
				if (!found) begin
					cur_q <= mem_rdata;
				end else begin
					root_q <= cur_q;
					cur_q  <= phase_end ? nb_q : start;
				end
			end
			ST_COMP_WR: begin
				cur_q <= phase_end ? nb_q : mem_rdata;
			end
			ST_LINK: begin
				res_q.accepted  <= (ra_q != root_q);
				res_q.root_node <= node_t'(root_q);
			end
			default: ;
		endcase
		if (phase_end && !side_b_q) begin
			ra_q <= phase_root;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

FILE: hdl/kruskal_union_find_edge_filter.sv
// Top level of the Kruskal edge filter: sequencer, parent store and result register.
//
// Channel   Dir  Payload                Beat
// edge_in   in   node_a, node_b         one edge
// result    out  accepted, root_node    one verdict per edge
//
// An edge passes an accept state, a read and a wait state per parent read on each root walk
// (one read port, registered read data), a read and a write state per node rewritten during
// compression, a link state and a result state. After reset the parent store is set to
// identity by a clearing pass over all 1024 entries; no edge is taken during it.
// A stalled result waits in the output register while the next edge is taken; the
// sequencer holds its finished verdict until that register frees.
`default_nettype none
`include "kruskal_union_find_edge_filter_defines.svh"
module kruskal_union_find_edge_filter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	kufe_edge_if.sink       edge_in,
	kufe_result_if.source   result
);
	import kufe_pkg::*;

	mem_req_t  mem_req;
	addr_t     mem_rdata;
	result_t   res;
	eng_stat_t stat;
	logic      res_ready;
	logic      out_valid_q;
	result_t   out_q;

	assign res_ready = !out_valid_q || result.ready;

	kufe_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_in   (edge_in),
		.res_ready (res_ready),
		.res       (res),
		.stat      (stat),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	kufe_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (MAX_NODES)
	) u_parent_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.push) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.push) begin
			out_q <= res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.accepted  = out_q.accepted;
	assign result.root_node = out_q.root_node;

	`KUFE_ASSERT_IMPL(a_no_self_link, clk, arst_n, mem_req.we && !stat.clearing, mem_req.waddr != mem_req.wdata, "parent store write would make a node its own parent outside clearing")
	`KUFE_ASSERT_NEXT(a_busy_after_edge, clk, arst_n, edge_in.valid && edge_in.ready, !edge_in.ready, "edge taken while the previous edge is still in work")
	`KUFE_ASSERT_IMPL(a_push_has_room, clk, arst_n, stat.push, !out_valid_q || result.ready, "verdict pushed into an occupied output register")

endmodule
`default_nettype wire
